### sv/shg_pkg.sv
// Shared constants and types for the spatial hash grid builder.
package shg_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int POS_W   = 24;
    localparam int CS_W    = 23;
    localparam int HASH_W  = 32;
    localparam int IDX_W   = 6;
    localparam logic [22:0] CELL_SIZE_RST = 23'd256;
    localparam logic [31:0] HASH_MUL_X = 32'd15823;
    localparam logic [31:0] HASH_MUL_Y = 32'd9737333;
    localparam logic [0:0] REG_CELL_SIZE = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic div_start;
        logic div_sel_y;
        logic hash_wr;
        logic mod_start;
        logic clr_we;
        logic cnt_we;
        logic key_we;
        logic pre_step;
        logic pre_clr;
        logic srt_rd;
        logic srt_we;
        logic out_rd;
        logic out_load;
        logic [6:0] addr;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic mod_done;
    } t_sts;
endpackage

### sv/shg_ram.sv
// Generic single-port-write RAM with registered read.
module shg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/shg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module shg_div #(
    parameter int NW = 32,
    parameter int DW = 23
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_sub;

    assign w_sh  = {r_rem[DW-1:0], r_quo[NW-1]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_sub[DW]) begin
                    r_rem <= w_sub;
                end else begin
                    r_rem <= w_sh;
                end
                r_quo <= {r_quo[NW-2:0], ~w_sub[DW]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[DW-1:0];
endmodule

### sv/shg_datapath.sv
// Datapath: divider, hash, key memories, counting sort and result register.
module shg_datapath
    import shg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [POS_W-1:0]  i_pos_x,
    input  logic [POS_W-1:0]  i_pos_y,
    input  logic [CS_W-1:0]   i_cell_size,
    input  logic [6:0]        i_count,
    input  logic              i_ovf,
    output logic [IDX_W-1:0]  o_entry_point,
    output logic [IDX_W-1:0]  o_entry_key,
    output logic              o_start_valid,
    output logic [IDX_W-1:0]  o_start_position,
    output logic              o_points_dropped
);
    localparam int AW = $clog2(MAX_POINTS);

    logic [AW-1:0]     w_a;
    logic              w_start;
    logic [31:0]       w_num;
    logic [31:0]       w_quo;
    logic [CS_W-1:0]   w_den;
    logic [CS_W-1:0]   w_rem;
    logic              w_ddone;
    logic [POS_W-1:0]  w_pos;
    logic [POS_W-1:0]  w_mag;
    logic              w_neg;
    logic              r_neg;
    logic [POS_W-1:0]  r_py;
    logic [31:0]       r_cx;
    logic [31:0]       w_cq;
    logic [31:0]       r_px;
    logic [31:0]       w_hash;
    logic [31:0]       w_hrd;
    logic [6:0]        w_krd;
    logic [6:0]        w_cnt_rd;
    logic [6:0]        w_nxt_rd;
    logic [6:0]        w_nxt_wd;
    logic [6:0]        w_st_rd;
    logic [5:0]        w_so_rd;
    logic [6:0]        r_pos;
    logic              r_mod_sel;
    logic [AW-1:0]     r_kaddr;
    logic [AW-1:0]     w_key_ra;
    logic [AW-1:0]     w_nxt_wa;
    logic [AW-1:0]     w_nxt_ra;
    logic              w_nxt_we;
    logic [6:0]        w_cnt_wd;
    logic [6:0]        w_st_wd;
    logic [CS_W-1:0]   w_cs;
    logic [AW-1:0]     r_kd;

    assign w_a  = i_cmd.addr[AW-1:0];
    assign w_cs = (i_cell_size == '0) ? CS_W'(1) : i_cell_size;

    // Division source: sign-magnitude coordinates, or a hash for the key.
    // The y coordinate is held from acceptance, since the word is gone by then.
    assign w_pos = i_cmd.div_sel_y ? r_py : i_pos_x;
    assign w_neg = w_pos[POS_W-1];
    assign w_mag = w_neg ? (~w_pos + 1'b1) : w_pos;
    assign w_start = i_cmd.div_start | i_cmd.mod_start;
    assign w_num = i_cmd.mod_start ? w_hrd : {8'd0, w_mag};
    assign w_den = i_cmd.mod_start ? CS_W'(i_count) : w_cs;

    shg_div #(.NW(32), .DW(CS_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_ddone),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    assign o_sts.div_done = w_ddone & ~r_mod_sel;
    assign o_sts.mod_done = w_ddone & r_mod_sel;
    assign w_cq = r_neg ? (32'd0 - w_quo) : w_quo;

    // The x quotient is held while y divides; both products are then registered
    // and summed for the hash write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_sel <= 1'b0;
        end else if (w_start) begin
            r_mod_sel <= i_cmd.mod_start;
        end
        if (i_cmd.div_start) begin
            r_neg <= w_neg;
        end
        if (i_cmd.div_start && !i_cmd.div_sel_y) begin
            r_py <= i_pos_y;
        end
        if (w_ddone && !r_mod_sel && i_cmd.div_start) begin
            r_cx <= w_cq;
        end
        if (w_ddone && !r_mod_sel && !i_cmd.div_start) begin
            r_px <= r_cx * HASH_MUL_X;
            r_cx <= w_cq * HASH_MUL_Y;
        end
        if (i_cmd.mod_start) begin
            r_kaddr <= w_a;
        end
        r_kd <= w_a;
    end
    assign w_hash = r_px + r_cx;

    shg_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_hash (
        .i_clk(i_clk), .i_we(i_cmd.hash_wr), .i_waddr(w_a), .i_wdata(w_hash),
        .i_raddr(w_a), .o_rdata(w_hrd)
    );

    // Key per point; bit 6 unused.
    assign w_key_ra = i_cmd.out_rd ? w_so_rd[AW-1:0] : w_a;
    shg_ram #(.WIDTH(7), .DEPTH(MAX_POINTS)) u_key (
        .i_clk(i_clk), .i_we(i_cmd.key_we), .i_waddr(r_kaddr),
        .i_wdata({1'b0, w_rem[5:0]}), .i_raddr(w_key_ra), .o_rdata(w_krd)
    );

    // Counts per key, later turned into next-position pointers.
    assign w_cnt_wd = i_cmd.clr_we ? 7'd0 : (w_cnt_rd + 7'd1);
    assign w_nxt_we = i_cmd.clr_we | i_cmd.cnt_we | i_cmd.pre_step | i_cmd.srt_we;
    always_comb begin
        w_nxt_wa = w_a;
        w_nxt_wd = w_cnt_wd;
        w_nxt_ra = w_a;
        if (i_cmd.cnt_we || i_cmd.srt_we) begin
            w_nxt_wa = w_krd[AW-1:0];
            w_nxt_ra = w_krd[AW-1:0];
        end
        if (i_cmd.srt_rd) begin
            w_nxt_ra = w_krd[AW-1:0];
        end
        if (i_cmd.pre_step) begin
            w_nxt_wa = r_kd;
            w_nxt_wd = r_pos;
        end
        if (i_cmd.srt_we) begin
            w_nxt_wd = w_cnt_rd + 7'd1;
        end
    end
    logic [6:0] w_cnt_mem;
    shg_ram #(.WIDTH(7), .DEPTH(MAX_POINTS)) u_cnt (
        .i_clk(i_clk), .i_we(w_nxt_we), .i_waddr(w_nxt_wa), .i_wdata(w_nxt_wd),
        .i_raddr(w_nxt_ra), .o_rdata(w_cnt_mem)
    );
    assign w_cnt_rd = w_cnt_mem;
    assign w_nxt_rd = w_cnt_mem;

    // Key start table, cleared on every build.
    assign w_st_wd = i_cmd.clr_we ? 7'd0
                   : ((w_nxt_rd != 7'd0) ? {1'b1, r_pos[5:0]} : 7'd0);
    shg_ram #(.WIDTH(7), .DEPTH(MAX_POINTS)) u_start (
        .i_clk(i_clk), .i_we(i_cmd.clr_we | i_cmd.pre_step),
        .i_waddr(i_cmd.clr_we ? w_a : r_kd), .i_wdata(w_st_wd),
        .i_raddr(w_a), .o_rdata(w_st_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.pre_clr) begin
            r_pos <= '0;
        end else if (i_cmd.pre_step) begin
            r_pos <= r_pos + w_nxt_rd;
        end
    end

    shg_ram #(.WIDTH(6), .DEPTH(MAX_POINTS)) u_sort (
        .i_clk(i_clk), .i_we(i_cmd.srt_we), .i_waddr(w_nxt_rd[AW-1:0]),
        .i_wdata(6'(r_kd)), .i_raddr(w_a), .o_rdata(w_so_rd)
    );

    // Output assembly: entry_key needs a second read of the key memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_rd) begin
            o_entry_point    <= w_so_rd;
            o_start_valid    <= w_st_rd[6];
            o_start_position <= w_st_rd[6] ? w_st_rd[5:0] : 6'd0;
            o_points_dropped <= i_ovf;
        end
        if (i_cmd.out_load) begin
            o_entry_key <= w_krd[5:0];
        end
    end
endmodule

### sv/shg_ctrl.sv
// Controller: capture, clear, key, count, prefix, scatter and emit phases.
module shg_ctrl
    import shg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_point_last,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_last,
    output t_cmd        o_cmd,
    input  t_sts        i_sts,
    output logic [6:0]  o_count,
    output logic        o_ovf
);
    localparam logic [3:0] S_IDLE = 4'd0,  S_DIVX = 4'd1,  S_DIVY = 4'd2,
                           S_HASH = 4'd3,  S_CLR  = 4'd4,  S_MOD  = 4'd5,
                           S_MODW = 4'd6,  S_CNT  = 4'd7,  S_CNTW = 4'd8,
                           S_PRE  = 4'd9,  S_PREW = 4'd10, S_SRT  = 4'd11,
                           S_SRTW = 4'd12, S_ORD  = 4'd13, S_OK   = 4'd14,
                           S_OUT  = 4'd15;

    logic [3:0] r_st, n_st;
    logic [6:0] r_cnt, n_cnt;
    logic       r_ovf, n_ovf;
    logic       r_last, n_last;
    logic [6:0] r_i, n_i;
    logic [1:0] r_w, n_w;
    t_cmd       w_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_ovf <= 1'b0; r_last <= 1'b0;
            r_i <= '0; r_w <= '0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ovf <= n_ovf; r_last <= n_last;
            r_i <= n_i; r_w <= n_w;
        end
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_ovf = r_ovf; n_last = r_last;
        n_i = r_i; n_w = r_w;
        w_c = '0;
        w_c.addr = r_i;
        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_point_last;
                    n_i = '0;
                    if (r_cnt < 7'(MAX_POINTS)) begin
                        w_c.div_start = 1'b1;
                        n_st = S_DIVX;
                    end else begin
                        n_ovf = 1'b1;
                        n_st = i_point_last ? S_CLR : S_IDLE;
                    end
                end
            end
            S_DIVX: if (i_sts.div_done) begin
                w_c.div_start = 1'b1; w_c.div_sel_y = 1'b1; n_st = S_DIVY;
            end
            S_DIVY: begin
                w_c.div_sel_y = 1'b1;
                if (i_sts.div_done) n_st = S_HASH;
            end
            S_HASH: begin
                w_c.hash_wr = 1'b1; w_c.addr = r_cnt;
                n_cnt = r_cnt + 7'd1;
                n_st = r_last ? S_CLR : S_IDLE;
            end
            S_CLR: begin
                w_c.clr_we = 1'b1;
                n_i = r_i + 7'd1;
                if (r_i == 7'(MAX_POINTS - 1)) begin
                    n_i = '0; n_st = S_MOD; n_w = '0;
                end
            end
            S_MOD: begin
                // The hash read is registered; the divider starts once its data is out.
                if (r_w == 2'd0) n_w = 2'd1;
                else begin
                    w_c.mod_start = 1'b1; n_w = '0; n_st = S_MODW;
                end
            end
            S_MODW: if (i_sts.mod_done) begin
                w_c.key_we = 1'b1;
                n_i = r_i + 7'd1;
                if (r_i + 7'd1 == r_cnt) begin n_i = '0; n_st = S_CNT; end
                else n_st = S_MOD;
            end
            S_CNT: n_st = S_CNTW;
            S_CNTW: begin
                // Key read done; read count next, then write it back.
                if (r_w == 2'd0) begin
                    w_c.srt_rd = 1'b1; n_w = 2'd1;
                end else begin
                    w_c.cnt_we = 1'b1; n_w = '0;
                    n_i = r_i + 7'd1;
                    if (r_i + 7'd1 == r_cnt) begin
                        n_i = '0; n_st = S_PRE; w_c.pre_clr = 1'b1;
                    end else n_st = S_CNT;
                end
            end
            S_PRE: n_st = S_PREW;
            S_PREW: begin
                w_c.pre_step = 1'b1;
                n_i = r_i + 7'd1;
                if (r_i + 7'd1 == r_cnt) begin n_i = '0; n_st = S_SRT; end
                else n_st = S_PRE;
            end
            S_SRT: n_st = S_SRTW;
            S_SRTW: begin
                if (r_w == 2'd0) begin
                    w_c.srt_rd = 1'b1; n_w = 2'd1;
                end else begin
                    w_c.srt_we = 1'b1; n_w = '0;
                    n_i = r_i + 7'd1;
                    if (r_i + 7'd1 == r_cnt) begin n_i = '0; n_st = S_ORD; end
                    else n_st = S_SRT;
                end
            end
            S_ORD: n_st = S_OK;
            S_OK: begin
                // Sorted entry and start are read; then read the key of that point.
                if (r_w == 2'd0) begin
                    w_c.out_rd = 1'b1; n_w = 2'd1;
                end else begin
                    w_c.out_load = 1'b1; n_w = '0; n_st = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_i = r_i + 7'd1;
                    if (r_i + 7'd1 == r_cnt) begin
                        n_i = '0; n_st = S_IDLE; n_cnt = '0; n_ovf = 1'b0;
                    end else n_st = S_ORD;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_cmd         = w_c;
    assign o_in_ready    = (r_st == S_IDLE);
    assign o_out_valid   = (r_st == S_OUT);
    assign o_result_last = (r_st == S_OUT) && (r_i + 7'd1 == r_cnt);
    assign o_count       = r_cnt;
    assign o_ovf         = r_ovf;
endmodule

### sv/spatial_hash_grid_build_core.sv
// Spatial hash grid builder: point capture, key sort and result emission.
// Each point runs, from acceptance until the input is ready again, through two
// passes of the shared iterative divider and a hash write. After the last point
// the build clears the count and start tables, computes the modulo-N keys per
// point (same divider), then runs count, prefix and scatter passes over the
// points, and emits N result words, each held until the receiver is ready.
// Input is held off during the build and emission.
module spatial_hash_grid_build_core
    import shg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [0:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic                     i_point_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [IDX_W-1:0]         o_entry_point,
    output logic [IDX_W-1:0]         o_entry_key,
    output logic                     o_start_valid,
    output logic [IDX_W-1:0]         o_start_position,
    output logic                     o_points_dropped,
    output logic                     o_result_last
);
    logic [CS_W-1:0] r_cell_size;
    t_cmd            w_cmd;
    t_sts            w_sts;
    logic [6:0]      w_count;
    logic            w_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= CELL_SIZE_RST;
        end else if (psel && penable && pwrite && paddr == REG_CELL_SIZE) begin
            r_cell_size <= pwdata[CS_W-1:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == REG_CELL_SIZE) ? {9'd0, r_cell_size} : 32'd0;

    shg_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid),
        .i_point_last(i_point_last), .o_in_ready(o_ready), .o_out_valid(o_valid),
        .i_out_ready(i_ready), .o_result_last(o_result_last), .o_cmd(w_cmd),
        .i_sts(w_sts), .o_count(w_count), .o_ovf(w_ovf)
    );

    shg_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_cell_size(r_cell_size),
        .i_count(w_count), .i_ovf(w_ovf), .o_entry_point(o_entry_point),
        .o_entry_key(o_entry_key), .o_start_valid(o_start_valid),
        .o_start_position(o_start_position), .o_points_dropped(o_points_dropped)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input and output both open");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_result_last) |=> o_ready)
        else $error("no return to idle after final word");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= 7'(MAX_POINTS)) else $error("point count over capacity");
`endif
endmodule
